[hw/rtl/row_peak_pair_color_compositor_core_macros.svh]
// Assertion helpers for the compositor core RTL.
`ifndef ROW_PEAK_PAIR_COLOR_COMPOSITOR_CORE_MACROS_SVH
`define ROW_PEAK_PAIR_COLOR_COMPOSITOR_CORE_MACROS_SVH

// same-cycle implication
`define RPPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rppc assertion failed");

// next-cycle implication
`define RPPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rppc assertion failed");

`endif

[hw/rtl/rppc_pkg.sv]
package rppc_pkg;

   localparam logic OP_MERGE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // owner code with bit 2 set means the row holds no colour
   localparam logic [2:0] NO_COLOR = 3'b100;

   typedef struct packed {
      logic       operation;
      logic [8:0] row;
      logic [7:0] sample_value;
      logic [1:0] channel_color;
   } req_type;

   typedef struct packed {
      logic [8:0]  out_row;
      logic [7:0]  top_value;
      logic [7:0]  second_value;
      logic        has_color;
      logic [1:0]  owner_color;
      logic [17:0] lut_address;
   } rsp_type;

   typedef struct packed {
      logic [2:0] owner;
      logic [7:0] top;
      logic [7:0] second;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{owner: NO_COLOR, top: 8'd0, second: 8'd0};

endpackage

[hw/rtl/row_peak_pair_color_compositor_core.sv]
// Row peak-pair colour compositor. Each row of a ROW_COUNT-deep memory holds a top amplitude,
// a runner-up and the colour owning the top; merge transactions fold a sample into their row
// and produce nothing, read transactions return the row's entry with its colour-table address
// and clear it. One transaction is taken per cycle unless input is held off: the row is read
// from the synchronous memory on acceptance and written back when the transaction retires,
// with the written entry forwarded when the next transaction hits the same row. A read result
// is registered when the read retires and sits in an output register; input is held off
// during the clearing pass and while that register is full and stalled and a further read is
// ready to retire. After reset a clearing pass writes every row; no transaction is accepted until it ends.
`include "row_peak_pair_color_compositor_core_macros.svh"

module row_peak_pair_color_compositor_core import rppc_pkg::*; #(
   parameter int ROW_COUNT = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(ROW_COUNT);

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_item_ff;
   logic              s1_in_range_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              fwd_valid_ff, fwd_valid_in;
   entry_type         fwd_entry_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic [31:0]       req_row_wide;
   logic [ADDR_W-1:0] req_addr;
   logic              req_in_range;
   logic              req_accept;
   logic              out_blocked;
   logic              s1_done;
   logic              s1_result;
   entry_type         mem_rd_entry;
   entry_type         cur_entry;
   entry_type         new_entry;
   logic              merge_wr;
   rsp_type           merge_result;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_entry;

   assign req_row_wide = 32'(req_data.row);
   assign req_addr     = req_row_wide[ADDR_W-1:0];
   assign req_in_range = req_row_wide < 32'(ROW_COUNT);

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign s1_done     = s1_valid_ff && (s1_item_ff.operation == OP_MERGE || !out_blocked);
   assign s1_result   = s1_done && s1_item_ff.operation == OP_READ;
   assign req_stall   = clearing_ff || (s1_valid_ff && !s1_done);
   assign req_accept  = req_valid && !req_stall;

   assign cur_entry = fwd_valid_ff ? fwd_entry_ff : mem_rd_entry;

   rppc_merge u_merge (
      .item       (s1_item_ff),
      .in_range   (s1_in_range_ff),
      .entry      (cur_entry),
      .entry_next (new_entry),
      .write_en   (merge_wr),
      .result     (merge_result)
   );

   assign wr_en    = clearing_ff || (s1_done && merge_wr);
   assign wr_addr  = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign wr_entry = clearing_ff ? EMPTY_ENTRY : new_entry;

   rppc_row_mem #(
      .ROW_COUNT (ROW_COUNT),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (req_accept),
      .rd_addr  (req_addr),
      .rd_entry (mem_rd_entry)
   );

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(ROW_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_done);
      // memory read on this edge misses the write-back of the retiring transaction
      fwd_valid_in = req_accept ? (s1_done && merge_wr && s1_addr_ff == req_addr)
                                : (fwd_valid_ff && !s1_done);
      rsp_valid_in = s1_result || out_blocked;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff     <= req_data;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         fwd_entry_ff   <= new_entry;
      end
      if (s1_result) begin
         rsp_data_ff <= merge_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RPPC_ASSERT_NOW(a_no_work_while_clearing, clock, reset, clearing_ff, !s1_valid_ff)
   `RPPC_ASSERT_NOW(a_fwd_needs_item, clock, reset, fwd_valid_ff, s1_valid_ff)
   `RPPC_ASSERT_NEXT(a_held_item_stays, clock, reset, s1_valid_ff && !s1_done, s1_valid_ff)
   `RPPC_ASSERT_NOW(a_result_from_read, clock, reset, $rose(rsp_valid_ff), $past(s1_result))

endmodule

[hw/rtl/rppc_row_mem.sv]
module rppc_row_mem import rppc_pkg::*; #(
   parameter int ROW_COUNT = 512,
   parameter int ADDR_W    = $clog2(ROW_COUNT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_entry,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_entry
);

   entry_type mem [ROW_COUNT];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

[hw/rtl/rppc_merge.sv]
module rppc_merge import rppc_pkg::*; (
   input  req_type   item,
   input  logic      in_range,
   input  entry_type entry,
   output entry_type entry_next,
   output logic      write_en,
   output rsp_type   result
);

   entry_type shown;
   logic      has;

   always_comb begin
      entry_next = entry;
      write_en   = in_range;
      if (item.operation == OP_READ) begin
         entry_next = EMPTY_ENTRY;
      end else if (entry.owner != {1'b0, item.channel_color}) begin
         if (entry.top <= item.sample_value) begin
            entry_next.owner  = {1'b0, item.channel_color};
            entry_next.top    = item.sample_value;
            entry_next.second = entry.top;
         end else if (entry.second < item.sample_value) begin
            entry_next.second = item.sample_value;
         end
      end else if (entry.top < item.sample_value) begin
         entry_next.top = item.sample_value;
      end
   end

   // rows past the store read back as empty
   assign shown = in_range ? entry : EMPTY_ENTRY;
   assign has   = ~shown.owner[2];

   always_comb begin
      result.out_row      = item.row;
      result.top_value    = shown.top;
      result.second_value = shown.second;
      result.has_color    = has;
      result.owner_color  = has ? shown.owner[1:0] : 2'd0;
      result.lut_address  = has ? {shown.owner[1:0], shown.top, shown.second} : 18'd0;
   end

endmodule

[dv/row_peak_pair_checker.sv]
module row_peak_pair_checker import rppc_pkg::*; #(
   parameter int ROW_COUNT = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      reads_in_flight
);

   logic [7:0] top_mem    [ROW_COUNT];
   logic [7:0] second_mem [ROW_COUNT];
   logic [2:0] owner_mem  [ROW_COUNT];
   rsp_type    row_result_q [$];
   int         errors = 0;

   task automatic clear_row(input int r);
      top_mem[r]    = 8'd0;
      second_mem[r] = 8'd0;
      owner_mem[r]  = NO_COLOR;
   endtask

   task automatic fold_sample(input req_type t);
      logic [7:0] cur_top;
      logic [2:0] cur_owner;
      // merges into rows beyond the memory are dropped
      if (int'(t.row) >= ROW_COUNT) return;
      cur_top   = top_mem[t.row];
      cur_owner = owner_mem[t.row];
      if (cur_owner != {1'b0, t.channel_color}) begin
         // ties go to the newcomer; an empty row always loses
         if (cur_top <= t.sample_value) begin
            second_mem[t.row] = cur_top;
            top_mem[t.row]    = t.sample_value;
            owner_mem[t.row]  = {1'b0, t.channel_color};
         end else if (second_mem[t.row] < t.sample_value) begin
            second_mem[t.row] = t.sample_value;
         end
      end else if (cur_top < t.sample_value) begin
         top_mem[t.row] = t.sample_value;
      end
   endtask

   task automatic take_entry(input logic [8:0] row, output rsp_type r);
      logic [7:0] cur_top;
      logic [7:0] cur_second;
      logic [2:0] cur_owner;
      logic       present;
      cur_top    = 8'd0;
      cur_second = 8'd0;
      cur_owner  = NO_COLOR;
      if (int'(row) < ROW_COUNT) begin
         cur_top    = top_mem[row];
         cur_second = second_mem[row];
         cur_owner  = owner_mem[row];
         clear_row(int'(row));
      end
      present        = !cur_owner[2];
      r.out_row      = row;
      r.top_value    = cur_top;
      r.second_value = cur_second;
      r.has_color    = present;
      r.owner_color  = present ? cur_owner[1:0] : 2'd0;
      r.lut_address  = present ? {cur_owner[1:0], cur_top, cur_second} : 18'd0;
   endtask

   task automatic check_field(input string name, input logic [8:0] row,
                              input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: row %0d %s mismatch, expected %0h, got %0h",
                  $time, row, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) clear_row(r);
         row_result_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (row_result_q.size() == 0) begin
               $display("%0t: row result with none pending, expected nothing, got %h",
                        $time, rsp_data);
               errors++;
            end else begin
               want = row_result_q.pop_front();
               check_field("out_row", want.out_row, 32'(want.out_row),
                           32'(rsp_data.out_row));
               check_field("top_value", want.out_row, 32'(want.top_value),
                           32'(rsp_data.top_value));
               check_field("second_value", want.out_row, 32'(want.second_value),
                           32'(rsp_data.second_value));
               check_field("has_color", want.out_row, 32'(want.has_color),
                           32'(rsp_data.has_color));
               check_field("owner_color", want.out_row, 32'(want.owner_color),
                           32'(rsp_data.owner_color));
               check_field("lut_address", want.out_row, 32'(want.lut_address),
                           32'(rsp_data.lut_address));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.operation == OP_READ) begin
               take_entry(req_data.row, want);
               row_result_q.insert(row_result_q.size(), want);
            end else begin
               fold_sample(req_data);
            end
         end
      end
      fail_count      <= errors;
      reads_in_flight <= row_result_q.size();
   end

endmodule

[dv/testbench.sv]
module testbench;
   import rppc_pkg::*;

   localparam int ROW_COUNT    = 512;
   localparam int RANDOM_ITEMS = 900;
   localparam int SEGMENT_LEN  = 50;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int         fail_count;
   int         reads_in_flight;
   int         cycles = 0;
   bit         quiet;
   logic [8:0] hot_rows [8];

   row_peak_pair_color_compositor_core #(.ROW_COUNT(ROW_COUNT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   row_peak_pair_checker #(.ROW_COUNT(ROW_COUNT)) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .reads_in_flight (reads_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("row_peak_pair_color_compositor_core verification failed");
         $finish;
      end
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send(input req_type t);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      gap = quiet ? 0 : pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic merge_into(input logic [8:0] row, input logic [7:0] value,
                             input logic [1:0] color);
      req_type t;
      t.operation     = OP_MERGE;
      t.row           = row;
      t.sample_value  = value;
      t.channel_color = color;
      send(t);
   endtask

   task automatic read_row(input logic [8:0] row);
      req_type t;
      t.operation     = OP_READ;
      t.row           = row;
      t.sample_value  = 8'($urandom);
      t.channel_color = 2'($urandom);
      send(t);
   endtask

   // most transactions land on a few hot rows so entries build up before a read
   function automatic req_type random_txn();
      req_type t;
      t.operation = ($urandom_range(0, 5) == 0) ? OP_READ : OP_MERGE;
      t.row = ($urandom_range(0, 9) < 7) ? hot_rows[$urandom_range(0, 7)] : 9'($urandom);
      case ($urandom_range(0, 9))
         0:       t.sample_value = 8'd0;
         1:       t.sample_value = 8'd255;
         2, 3:    t.sample_value = 8'($urandom_range(120, 127));
         default: t.sample_value = 8'($urandom);
      endcase
      t.channel_color = 2'($urandom);
      return t;
   endfunction

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = quiet ? 0 : pause_len();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      quiet     <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // rows untouched since reset read back black
      read_row(9'd0);
      read_row(9'd511);
      // zero sample still claims an empty row
      merge_into(9'd0, 8'd0, 2'd0);
      read_row(9'd0);
      // same colour never demotes; a tie from another colour takes over
      merge_into(9'd511, 8'd255, 2'd3);
      merge_into(9'd511, 8'd100, 2'd3);
      merge_into(9'd511, 8'd255, 2'd2);
      merge_into(9'd511, 8'd50, 2'd3);
      read_row(9'd511);
      // raise top, raise second, ignore smaller, then takeover
      merge_into(9'd5, 8'd10, 2'd1);
      merge_into(9'd5, 8'd20, 2'd1);
      merge_into(9'd5, 8'd15, 2'd2);
      merge_into(9'd5, 8'd12, 2'd3);
      merge_into(9'd5, 8'd200, 2'd0);
      read_row(9'd5);
      read_row(9'd5);
      merge_into(9'd256, 8'd128, 2'd2);
      merge_into(9'd256, 8'd127, 2'd1);
      read_row(9'd256);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            quiet <= ($urandom_range(0, 3) == 0);
            foreach (hot_rows[k])
               hot_rows[k] = ($urandom_range(0, 15) == 0) ? 9'd511 : 9'($urandom);
         end
         send(random_txn());
      end
      req_valid <= 1'b0;

      // let the count from the last accepting edge settle first
      @(posedge clock);
      while (reads_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("row_peak_pair_color_compositor_core verification clean");
      else
         $display("row_peak_pair_color_compositor_core verification failed");
      $finish;
   end

endmodule
